[sv/svcfc_pkg.sv]
// Shared types and constants for the servo command frame codec.
// No dependencies; imported by the controller, the datapath and the top level.
package svcfc_pkg;

  typedef enum logic [1:0] {
    CMD_CONTROL  = 2'd0,
    CMD_ENTER    = 2'd1,
    CMD_EXIT     = 2'd2,
    CMD_FEEDBACK = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_EMITTED   = 2'd0,
    ST_NO_CHANGE = 2'd1,
    ST_REFUSED   = 2'd2,
    ST_DECODED   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_LOAD,
    S_DIV,
    S_SAVE,
    S_RESULT
  } state_e;

  // configuration register indexes
  localparam logic [3:0] REG_POS_LO  = 4'd0;
  localparam logic [3:0] REG_POS_HI  = 4'd1;
  localparam logic [3:0] REG_VEL_LO  = 4'd2;
  localparam logic [3:0] REG_VEL_HI  = 4'd3;
  localparam logic [3:0] REG_TRQ_LO  = 4'd4;
  localparam logic [3:0] REG_TRQ_HI  = 4'd5;
  localparam logic [3:0] REG_KP_HI   = 4'd6;
  localparam logic [3:0] REG_KD_HI   = 4'd7;

  // quantization slots of a control command
  localparam logic [2:0] SLOT_POS = 3'd0;
  localparam logic [2:0] SLOT_VEL = 3'd1;
  localparam logic [2:0] SLOT_KP  = 3'd2;
  localparam logic [2:0] SLOT_KD  = 3'd3;
  localparam logic [2:0] SLOT_TRQ = 3'd4;
  // decode slots of a feedback command
  localparam logic [2:0] SLOT_CUR = 3'd2;

  localparam logic signed [31:0] KP_LOW = 32'sd0;
  localparam logic signed [31:0] KD_LOW = 32'sd0;
  localparam logic signed [31:0] CUR_LIMIT_Q = 32'sd3932160;

  localparam logic [7:0] FILL_BYTE  = 8'hFF;
  localparam logic [7:0] ENTER_BYTE = 8'hFC;
  localparam logic [7:0] EXIT_BYTE  = 8'hFD;

  localparam logic signed [31:0] POS_LO_RST = -32'sd819200;
  localparam logic signed [31:0] POS_HI_RST = 32'sd819200;
  localparam logic signed [31:0] VEL_LO_RST = -32'sd524288;
  localparam logic signed [31:0] VEL_HI_RST = 32'sd524288;
  localparam logic signed [31:0] TRQ_LO_RST = -32'sd1179648;
  localparam logic signed [31:0] TRQ_HI_RST = 32'sd1179648;
  localparam logic [30:0] KP_HI_RST = 31'd32768000;
  localparam logic [30:0] KD_HI_RST = 31'd327680;

  typedef struct packed {
    logic       capture;
    logic       setup;
    logic       load;
    logic       step;
    logic       save;
    logic       publish;
    logic       decode;
    logic [2:0] slot;
    cmd_e       cmd;
    status_e    status;
  } ctl_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_status_t;

endpackage

[sv/svcfc_controller.sv]
// Sequencer for the servo command frame codec: mode bit, slot walk, result handshake.
// Depends on svcfc_pkg.
module svcfc_controller (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_command,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  svcfc_pkg::dp_status_t dp_st,
  output svcfc_pkg::ctl_cmd_t   ctl
);
  import svcfc_pkg::*;

  state_e     state_r, state_nxt;
  logic [2:0] slot_r, slot_nxt;
  cmd_e       cmd_r, cmd_nxt;
  status_e    status_r, status_nxt;
  logic       mode_r, mode_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept, last_slot, can_pub;
  cmd_e       in_cmd;

  assign in_cmd    = cmd_e'(in_command);
  assign accept    = in_valid && (state_r == S_IDLE);
  assign last_slot = (cmd_r == CMD_FEEDBACK) ? (slot_r == SLOT_CUR) : (slot_r == SLOT_TRQ);
  assign can_pub   = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt  = state_r;
    slot_nxt   = slot_r;
    cmd_nxt    = cmd_r;
    status_nxt = status_r;
    mode_nxt   = mode_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt  = in_cmd;
          slot_nxt = SLOT_POS;
          case (in_cmd)
            CMD_CONTROL: begin
              if (mode_r) begin
                status_nxt = ST_EMITTED;
                state_nxt  = S_SETUP;
              end else begin
                status_nxt = ST_REFUSED;
                state_nxt  = S_RESULT;
              end
            end
            CMD_ENTER, CMD_EXIT: begin
              state_nxt = S_RESULT;
              if (mode_r != (in_cmd == CMD_ENTER)) begin
                status_nxt = ST_EMITTED;
                mode_nxt   = (in_cmd == CMD_ENTER);
              end else begin
                status_nxt = ST_NO_CHANGE;
              end
            end
            default: begin
              status_nxt = ST_DECODED;
              state_nxt  = S_SETUP;
            end
          endcase
        end
      end
      S_SETUP: state_nxt = S_LOAD;
      S_LOAD:  state_nxt = S_DIV;
      S_DIV:   if (dp_st.div_last) state_nxt = S_SAVE;
      S_SAVE: begin
        if (last_slot) begin
          state_nxt = S_RESULT;
        end else begin
          slot_nxt  = slot_r + 3'd1;
          state_nxt = S_SETUP;
        end
      end
      S_RESULT: if (can_pub) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl         = '0;
    ctl.capture = accept;
    ctl.setup   = (state_r == S_SETUP);
    ctl.load    = (state_r == S_LOAD);
    ctl.step    = (state_r == S_DIV);
    ctl.save    = (state_r == S_SAVE);
    ctl.publish = (state_r == S_RESULT) && can_pub;
    ctl.decode  = (cmd_r == CMD_FEEDBACK);
    ctl.slot    = slot_r;
    ctl.cmd     = cmd_r;
    ctl.status  = status_r;
    in_ready    = (state_r == S_IDLE);
    out_valid_nxt = ctl.publish ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slot_r      <= SLOT_POS;
      cmd_r       <= CMD_CONTROL;
      status_r    <= ST_NO_CHANGE;
      mode_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      cmd_r       <= cmd_nxt;
      status_r    <= status_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[sv/svcfc_datapath.sv]
// Datapath of the servo command frame codec: limits, operand setup, shared
// restoring divider, code and value stores, result registers. Depends on svcfc_pkg.
module svcfc_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  svcfc_pkg::ctl_cmd_t   ctl,
  output svcfc_pkg::dp_status_t dp_st,
  input  logic                  cfg_we,
  input  logic [3:0]            cfg_index,
  input  logic [31:0]           cfg_data,
  input  logic signed [31:0]    in_target_position,
  input  logic signed [31:0]    in_target_speed,
  input  logic signed [31:0]    in_stiffness,
  input  logic signed [31:0]    in_damping,
  input  logic signed [31:0]    in_feedforward_torque,
  input  logic [63:0]           in_frame_in,
  output logic [1:0]            out_status,
  output logic                  out_frame_valid,
  output logic [63:0]           out_frame_out,
  output logic [7:0]            out_reported_id,
  output logic signed [31:0]    out_reported_position,
  output logic signed [31:0]    out_reported_speed,
  output logic signed [22:0]    out_reported_current,
  output logic signed [7:0]     out_reported_temperature,
  output logic [7:0]            out_reported_fault
);
  import svcfc_pkg::*;

  logic signed [31:0] pos_lo_r, pos_hi_r, vel_lo_r, vel_hi_r, trq_lo_r, trq_hi_r;
  logic [30:0]        kp_hi_r, kd_hi_r;
  logic signed [31:0] tp_r, ts_r, kp_r, kd_r, tq_r;
  logic [63:0]        fin_r;

  logic signed [32:0] sel_x, sel_lo, sel_hi;
  logic [15:0]        sel_code;
  logic               sel_wide;
  logic signed [33:0] span_w;
  logic               bad_w;
  logic [31:0]        off_w;

  logic [31:0]        span_r, off_r;
  logic signed [31:0] lo_r;
  logic               bad_r, wide_r;

  logic [47:0]        mq_w, prod_w, acc_w;
  logic [48:0]        num_w;
  logic [32:0]        den_w;

  logic [32:0]        rem_r, den_r;
  logic [15:0]        low_r;
  logic [31:0]        quo_r;
  logic [5:0]         cnt_r;
  logic [33:0]        trial;
  logic               fits;

  logic [47:0]        acc_r, acc_nxt, fold_hi, fold_lo, fold_m;
  logic [31:0]        fold_add;

  logic [15:0]        p_code_r;
  logic [11:0]        v_code_r, kp_code_r, kd_code_r, t_code_r;
  logic [31:0]        rep_pos_r, rep_spd_r, value_w;
  logic [22:0]        rep_cur_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_lo_r <= POS_LO_RST;
      pos_hi_r <= POS_HI_RST;
      vel_lo_r <= VEL_LO_RST;
      vel_hi_r <= VEL_HI_RST;
      trq_lo_r <= TRQ_LO_RST;
      trq_hi_r <= TRQ_HI_RST;
      kp_hi_r  <= KP_HI_RST;
      kd_hi_r  <= KD_HI_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POS_LO: pos_lo_r <= cfg_data;
        REG_POS_HI: pos_hi_r <= cfg_data;
        REG_VEL_LO: vel_lo_r <= cfg_data;
        REG_VEL_HI: vel_hi_r <= cfg_data;
        REG_TRQ_LO: trq_lo_r <= cfg_data;
        REG_TRQ_HI: trq_hi_r <= cfg_data;
        REG_KP_HI:  kp_hi_r  <= cfg_data[30:0];
        REG_KD_HI:  kd_hi_r  <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // hold the request payload
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      tp_r  <= in_target_position;
      ts_r  <= in_target_speed;
      kp_r  <= in_stiffness;
      kd_r  <= in_damping;
      tq_r  <= in_feedforward_torque;
      fin_r <= in_frame_in;
    end
  end

  // operand select for the current slot
  always_comb begin
    sel_x    = {tp_r[31], tp_r};
    sel_lo   = {pos_lo_r[31], pos_lo_r};
    sel_hi   = {pos_hi_r[31], pos_hi_r};
    sel_wide = 1'b0;
    sel_code = {4'd0, fin_r[31:20]};
    case (ctl.slot)
      SLOT_POS: begin
        sel_wide = 1'b1;
        sel_code = fin_r[55:40];
      end
      SLOT_VEL: begin
        sel_x    = {ts_r[31], ts_r};
        sel_lo   = {vel_lo_r[31], vel_lo_r};
        sel_hi   = {vel_hi_r[31], vel_hi_r};
        sel_code = {4'd0, fin_r[39:28]};
      end
      SLOT_KP: begin
        if (ctl.decode) begin
          sel_lo   = -{CUR_LIMIT_Q[31], CUR_LIMIT_Q};
          sel_hi   = {CUR_LIMIT_Q[31], CUR_LIMIT_Q};
          sel_code = {4'd0, fin_r[27:16]};
        end else begin
          sel_x  = {kp_r[31], kp_r};
          sel_lo = {KP_LOW[31], KP_LOW};
          sel_hi = {2'b00, kp_hi_r};
        end
      end
      SLOT_KD: begin
        sel_x  = {kd_r[31], kd_r};
        sel_lo = {KD_LOW[31], KD_LOW};
        sel_hi = {2'b00, kd_hi_r};
      end
      SLOT_TRQ: begin
        sel_x  = {tq_r[31], tq_r};
        sel_lo = {trq_lo_r[31], trq_lo_r};
        sel_hi = {trq_hi_r[31], trq_hi_r};
      end
      default: ;
    endcase
  end

  // span and clamped offset, or the received code for a decode
  always_comb begin
    span_w = {sel_hi[32], sel_hi} - {sel_lo[32], sel_lo};
    bad_w  = span_w[33] || (span_w == 34'sd0);
    if (ctl.decode)          off_w = {16'd0, sel_code};
    else if (sel_x <= sel_lo) off_w = 32'd0;
    else if (sel_x >= sel_hi) off_w = span_w[31:0];
    else                      off_w = 32'(sel_x - sel_lo);
  end

  always_ff @(posedge clk) begin
    if (ctl.setup) begin
      span_r <= span_w[31:0];
      off_r  <= off_w;
      lo_r   <= sel_lo[31:0];
      bad_r  <= bad_w;
      wide_r <= sel_wide;
    end
  end

  // dividend and divisor for a quantization; folded operand for a decode
  always_comb begin
    mq_w   = (wide_r ? {off_r, 16'd0} : {4'd0, off_r, 12'd0}) - {16'd0, off_r};
    prod_w = off_r[15:0] * span_r;
    acc_w  = bad_r ? 48'd0 : prod_w + (wide_r ? 48'd32767 : 48'd2047);
    if (bad_r) begin
      num_w = '0;
      den_w = 33'd1;
    end else begin
      num_w = {mq_w, 1'b0} + {17'd0, span_r};
      den_w = {span_r, 1'b0};
    end
  end

  // one quotient bit a cycle
  assign trial = {rem_r, low_r[15]};
  assign fits  = trial >= {1'b0, den_r};

  // divide by 2^bits - 1: fold the high digits into the low ones, add them to the quotient
  assign fold_hi = wide_r ? {16'd0, acc_r[47:16]} : {12'd0, acc_r[47:12]};
  assign fold_lo = wide_r ? {32'd0, acc_r[15:0]} : {36'd0, acc_r[11:0]};
  assign fold_m  = wide_r ? 48'd65535 : 48'd4095;

  always_comb begin
    if (fold_hi != 48'd0) begin
      acc_nxt  = fold_hi + fold_lo;
      fold_add = fold_hi[31:0];
    end else if (acc_r == fold_m) begin
      acc_nxt  = 48'd0;
      fold_add = 32'd1;
    end else begin
      acc_nxt  = acc_r;
      fold_add = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctl.load) begin
      cnt_r <= 6'd16;
    end else if (ctl.step) begin
      cnt_r <= cnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      den_r <= den_w;
      quo_r <= '0;
      rem_r <= num_w[48:16];
      low_r <= num_w[15:0];
      acc_r <= acc_w;
    end else if (ctl.step) begin
      if (ctl.decode) begin
        acc_r <= acc_nxt;
        quo_r <= quo_r + fold_add;
      end else begin
        rem_r <= fits ? 33'(trial - {1'b0, den_r}) : trial[32:0];
        low_r <= {low_r[14:0], 1'b0};
        quo_r <= {quo_r[30:0], fits};
      end
    end
  end

  assign dp_st.div_last = ctl.decode ? (acc_nxt < fold_m) : (cnt_r == 6'd1);
  assign value_w = lo_r + quo_r;

  // drop each finished code or value into its slot
  always_ff @(posedge clk) begin
    if (ctl.save) begin
      if (ctl.decode) begin
        case (ctl.slot)
          SLOT_POS: rep_pos_r <= value_w;
          SLOT_VEL: rep_spd_r <= value_w;
          default:  rep_cur_r <= value_w[22:0];
        endcase
      end else begin
        case (ctl.slot)
          SLOT_POS: p_code_r  <= quo_r[15:0];
          SLOT_VEL: v_code_r  <= quo_r[11:0];
          SLOT_KP:  kp_code_r <= quo_r[11:0];
          SLOT_KD:  kd_code_r <= quo_r[11:0];
          default:  t_code_r  <= quo_r[11:0];
        endcase
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (ctl.publish) begin
      out_status      <= ctl.status;
      out_frame_valid <= (ctl.status == ST_EMITTED);
      out_frame_out   <= '0;
      if (ctl.status == ST_EMITTED) begin
        case (ctl.cmd)
          CMD_CONTROL:
            out_frame_out <= {p_code_r, v_code_r, kp_code_r, kd_code_r, t_code_r};
          CMD_ENTER:
            out_frame_out <= {{7{FILL_BYTE}}, ENTER_BYTE};
          default:
            out_frame_out <= {{7{FILL_BYTE}}, EXIT_BYTE};
        endcase
      end
      if (ctl.cmd == CMD_FEEDBACK) begin
        out_reported_id          <= fin_r[63:56];
        out_reported_position    <= rep_pos_r;
        out_reported_speed       <= rep_spd_r;
        out_reported_current     <= rep_cur_r;
        out_reported_temperature <= fin_r[15:8];
        out_reported_fault       <= fin_r[7:0];
      end else begin
        out_reported_id          <= '0;
        out_reported_position    <= '0;
        out_reported_speed       <= '0;
        out_reported_current     <= '0;
        out_reported_temperature <= '0;
        out_reported_fault       <= '0;
      end
    end
  end

endmodule

[sv/servo_command_frame_codec_unit.sv]
// Top level of the servo command frame codec: controller plus datapath.
// Depends on svcfc_pkg, svcfc_controller and svcfc_datapath.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------
//  in_     | request   | in_valid / in_ready  | command, set-points, feedback frame
//  out_    | result    | out_valid / out_ready| status, frame, reported fields
//  cfg_    | write     | cfg_we               | cfg_index, cfg_data
//
// A control request runs five quantizations on the shared one-bit-a-cycle
// restoring divider, each of setup, load, divider steps and save, between
// accept and publish. A feedback request runs three decodes, each of setup,
// load, digit-fold steps (divide by 2^bits - 1) and save, between accept and
// publish; enter and exit go from accept straight to publish.
// Reset (rst_n low, synchronous) restores the limits and leaves motor mode.
// One request is in flight at a time; a stalled result holds in the output
// registers while the next request is accepted and worked on.
module servo_command_frame_codec_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_command,
  input  logic signed [31:0] in_target_position,
  input  logic signed [31:0] in_target_speed,
  input  logic signed [31:0] in_stiffness,
  input  logic signed [31:0] in_damping,
  input  logic signed [31:0] in_feedforward_torque,
  input  logic [63:0]        in_frame_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic               out_frame_valid,
  output logic [63:0]        out_frame_out,
  output logic [7:0]         out_reported_id,
  output logic signed [31:0] out_reported_position,
  output logic signed [31:0] out_reported_speed,
  output logic signed [22:0] out_reported_current,
  output logic signed [7:0]  out_reported_temperature,
  output logic [7:0]         out_reported_fault,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import svcfc_pkg::*;

  ctl_cmd_t   ctl;
  dp_status_t dp_st;

  // sequencing: accept, walk the slots, publish
  svcfc_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_command(in_command),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dp_st     (dp_st),
    .ctl       (ctl)
  );

  // arithmetic, limit registers and result registers
  svcfc_datapath u_dp (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .ctl                     (ctl),
    .dp_st                   (dp_st),
    .cfg_we                  (cfg_we),
    .cfg_index               (cfg_index),
    .cfg_data                (cfg_data),
    .in_target_position      (in_target_position),
    .in_target_speed         (in_target_speed),
    .in_stiffness            (in_stiffness),
    .in_damping              (in_damping),
    .in_feedforward_torque   (in_feedforward_torque),
    .in_frame_in             (in_frame_in),
    .out_status              (out_status),
    .out_frame_valid         (out_frame_valid),
    .out_frame_out           (out_frame_out),
    .out_reported_id         (out_reported_id),
    .out_reported_position   (out_reported_position),
    .out_reported_speed      (out_reported_speed),
    .out_reported_current    (out_reported_current),
    .out_reported_temperature(out_reported_temperature),
    .out_reported_fault      (out_reported_fault)
  );

`ifndef SYNTHESIS
  // a frame is flagged for transmit exactly when one was emitted
  a_valid_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frame_valid == (out_status == ST_EMITTED)))
    else $error("frame_valid disagrees with status");

  // decoded feedback never carries an outgoing frame
  a_decode_no_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_DECODED) |-> (out_frame_out == 64'd0))
    else $error("feedback result carries a frame");

  // an accepted request closes the input until it is finished
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another is in flight");
`endif

endmodule

[tb/sv/svcfc_frame_checker.sv]
`timescale 1ns / 1ps
// Checker for the servo command frame codec: tracks limits and motor mode, predicts each
// result and compares it with the block's output. Depends on svcfc_pkg only.
module svcfc_frame_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_command,
  input  logic signed [31:0] in_target_position,
  input  logic signed [31:0] in_target_speed,
  input  logic signed [31:0] in_stiffness,
  input  logic signed [31:0] in_damping,
  input  logic signed [31:0] in_feedforward_torque,
  input  logic [63:0]        in_frame_in,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         out_status,
  input  logic               out_frame_valid,
  input  logic [63:0]        out_frame_out,
  input  logic [7:0]         out_reported_id,
  input  logic signed [31:0] out_reported_position,
  input  logic signed [31:0] out_reported_speed,
  input  logic signed [22:0] out_reported_current,
  input  logic signed [7:0]  out_reported_temperature,
  input  logic [7:0]         out_reported_fault,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 errors,
  output int                 pending,
  output int                 results
);
  import svcfc_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic        frame_valid;
    logic [63:0] frame;
    logic [7:0]  id;
    logic [31:0] position;
    logic [31:0] speed;
    logic [22:0] current;
    logic [7:0]  temperature;
    logic [7:0]  fault;
  } codec_result_t;

  codec_result_t expected_frames[$];

  longint pos_lo, pos_hi, vel_lo, vel_hi, trq_lo, trq_hi, kp_hi, kd_hi;
  bit     motor_mode;

  assign pending = expected_frames.size();

  function automatic longint quantize_code(longint x, longint lo, longint hi, int bits);
    longint span;
    longint m;
    longint off;
    span = hi - lo;
    m    = (longint'(1) << bits) - 1;
    if (span <= 0) return 0;
    if (x <= lo) off = 0;
    else if (x >= hi) off = span;
    else off = x - lo;
    return (2 * off * m + span) / (2 * span);
  endfunction

  function automatic longint dequantize_code(longint code, longint lo, longint hi, int bits);
    longint span;
    longint m;
    span = hi - lo;
    m    = (longint'(1) << bits) - 1;
    if (span <= 0) return lo;
    if (code > m) code = m;
    return lo + (2 * code * span + m) / (2 * m);
  endfunction

  function automatic codec_result_t predict_result();
    codec_result_t r;
    logic [63:0]   f;
    longint        p, v, kp, kd, t;
    longint        pc, vc, ic;
    r = '0;
    f = in_frame_in;
    r.status = ST_NO_CHANGE;
    case (cmd_e'(in_command))
      CMD_CONTROL: begin
        if (!motor_mode) begin
          r.status = ST_REFUSED;
        end else begin
          p  = quantize_code(longint'(in_target_position), pos_lo, pos_hi, 16);
          v  = quantize_code(longint'(in_target_speed), vel_lo, vel_hi, 12);
          kp = quantize_code(longint'(in_stiffness), longint'(KP_LOW), kp_hi, 12);
          kd = quantize_code(longint'(in_damping), longint'(KD_LOW), kd_hi, 12);
          t  = quantize_code(longint'(in_feedforward_torque), trq_lo, trq_hi, 12);
          r.frame       = (p << 48) | (v << 36) | (kp << 24) | (kd << 12) | t;
          r.status      = ST_EMITTED;
          r.frame_valid = 1'b1;
        end
      end
      CMD_ENTER, CMD_EXIT: begin
        // only a change of mode emits the special frame
        if (motor_mode != (in_command == CMD_ENTER)) begin
          r.frame = {{7{FILL_BYTE}}, (in_command == CMD_ENTER) ? ENTER_BYTE : EXIT_BYTE};
          motor_mode    = (in_command == CMD_ENTER);
          r.status      = ST_EMITTED;
          r.frame_valid = 1'b1;
        end
      end
      default: begin
        pc = {f[55:48], f[47:40]};
        vc = {f[39:32], f[31:28]};
        ic = {f[27:24], f[23:16]};
        r.status      = ST_DECODED;
        r.id          = f[63:56];
        r.position    = 32'(dequantize_code(pc, pos_lo, pos_hi, 16));
        r.speed       = 32'(dequantize_code(vc, vel_lo, vel_hi, 12));
        r.current     = 23'(dequantize_code(ic, -longint'(CUR_LIMIT_Q),
                                            longint'(CUR_LIMIT_Q), 12));
        r.temperature = f[15:8];
        r.fault       = f[7:0];
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("MISMATCH result %0d %s: got 0x%0h expected 0x%0h", results, field, got, want);
    errors++;
  endtask

  task automatic compare_result(codec_result_t want);
    if (out_status != want.status) report_mismatch("status", out_status, want.status);
    if (out_frame_valid != want.frame_valid)
      report_mismatch("frame_valid", out_frame_valid, want.frame_valid);
    if (out_frame_out != want.frame) report_mismatch("frame_out", out_frame_out, want.frame);
    if (out_reported_id != want.id) report_mismatch("id", out_reported_id, want.id);
    if (out_reported_position != want.position)
      report_mismatch("position", out_reported_position, want.position);
    if (out_reported_speed != want.speed)
      report_mismatch("speed", out_reported_speed, want.speed);
    if (out_reported_current != want.current)
      report_mismatch("current", out_reported_current, want.current);
    if (out_reported_temperature != want.temperature)
      report_mismatch("temperature", out_reported_temperature, want.temperature);
    if (out_reported_fault != want.fault)
      report_mismatch("fault", out_reported_fault, want.fault);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pos_lo = POS_LO_RST;  pos_hi = POS_HI_RST;
      vel_lo = VEL_LO_RST;  vel_hi = VEL_HI_RST;
      trq_lo = TRQ_LO_RST;  trq_hi = TRQ_HI_RST;
      kp_hi  = KP_HI_RST;   kd_hi  = KD_HI_RST;
      motor_mode = 1'b0;
      errors  = 0;
      results = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_POS_LO: pos_lo = longint'($signed(cfg_data));
          REG_POS_HI: pos_hi = longint'($signed(cfg_data));
          REG_VEL_LO: vel_lo = longint'($signed(cfg_data));
          REG_VEL_HI: vel_hi = longint'($signed(cfg_data));
          REG_TRQ_LO: trq_lo = longint'($signed(cfg_data));
          REG_TRQ_HI: trq_hi = longint'($signed(cfg_data));
          REG_KP_HI:  kp_hi  = longint'(cfg_data[30:0]);
          REG_KD_HI:  kd_hi  = longint'(cfg_data[30:0]);
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_frames.size() == 0) begin
          report_mismatch("unexpected result, status", out_status, 0);
        end else begin
          compare_result(expected_frames.pop_front());
        end
        results++;
      end
      if (in_valid && in_ready) expected_frames.push_back(predict_result());
    end
  end

endmodule

[tb/sv/tb_servo_command_frame_codec_unit.sv]
`timescale 1ns / 1ps
// Top of the servo command frame codec testbench: clock, reset, requests, limits and verdict.
// Depends on svcfc_pkg, servo_command_frame_codec_unit and svcfc_frame_checker.
module tb_servo_command_frame_codec_unit;
  import svcfc_pkg::*;

  // longest quiet stretch: the long receiver hold-off plus a control request, several times
  localparam int IDLE_LIMIT  = 6000;
  localparam int LONG_HOLD   = 400;
  localparam int PHASE_ITEMS = 270;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_command = CMD_CONTROL;
  logic signed [31:0] in_target_position = '0;
  logic signed [31:0] in_target_speed = '0;
  logic signed [31:0] in_stiffness = '0;
  logic signed [31:0] in_damping = '0;
  logic signed [31:0] in_feedforward_torque = '0;
  logic [63:0]        in_frame_in = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_status;
  logic               out_frame_valid;
  logic [63:0]        out_frame_out;
  logic [7:0]         out_reported_id;
  logic signed [31:0] out_reported_position;
  logic signed [31:0] out_reported_speed;
  logic signed [22:0] out_reported_current;
  logic signed [7:0]  out_reported_temperature;
  logic [7:0]         out_reported_fault;
  logic               cfg_we = 1'b0;
  logic [3:0]         cfg_index = REG_POS_LO;
  logic [31:0]        cfg_data = '0;

  int errors, pending, results;
  int requests = 0;
  int settings = 1;
  int idle_cycles = 0;
  bit hold_request = 1'b0;   // receiver takes one long hold-off when set
  bit fast_phase = 1'b0;     // no idling on either side while set
  bit sent_mode = 1'b0;      // motor mode as the requests sent so far leave it
  logic [31:0] limit_plan[8];

  always #5 clk = ~clk;

  servo_command_frame_codec_unit DUT (.*);

  svcfc_frame_checker u_checker (.*);

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Receiver: draw a wait per result, hold ready low for it, then take the result.
  initial begin : receiver
    int wait_cycles;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        wait_cycles = LONG_HOLD;
      end else begin
        wait_cycles = fast_phase ? 0 : $urandom_range(0, 12);
      end
      if (wait_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Offer one request, hold it until accepted, then draw the gap before the next.
  task automatic send_request(cmd_e cmd, logic [31:0] pos, logic [31:0] spd, logic [31:0] kp,
                              logic [31:0] kd, logic [31:0] trq, logic [63:0] frame);
    int gap;
    @(negedge clk);
    in_valid              <= 1'b1;
    in_command            <= cmd;
    in_target_position    <= pos;
    in_target_speed       <= spd;
    in_stiffness          <= kp;
    in_damping            <= kd;
    in_feedforward_torque <= trq;
    in_frame_in           <= frame;
    do @(posedge clk); while (!in_ready);
    requests++;
    if (cmd == CMD_ENTER) sent_mode = 1'b1;
    if (cmd == CMD_EXIT) sent_mode = 1'b0;
    gap = fast_phase ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Write all eight limits from limit_plan, plus one write to an unused index.
  task automatic apply_limits();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (4) @(negedge clk);
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 4'(i);
      cfg_data  <= limit_plan[i];
      @(negedge clk);
    end
    // ignored write: index past the last register
    cfg_index <= REG_KD_HI + 4'd1 + 4'($urandom_range(0, 7));
    cfg_data  <= $urandom;
    @(negedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  // Set-point near a limit, inside the range, at an extreme, near zero or fully random.
  function automatic logic [31:0] pick_value(longint lo, longint hi);
    longint span;
    span = hi - lo;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'(lo + $signed($urandom_range(0, 4)) - 2);
      2: return 32'(hi + $signed($urandom_range(0, 4)) - 2);
      3: return (span > 0) ? 32'(lo + longint'($urandom) % span) : $urandom;
      4: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return 32'($signed($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  task automatic send_random_control();
    send_request(CMD_CONTROL,
                 pick_value($signed(limit_plan[REG_POS_LO]), $signed(limit_plan[REG_POS_HI])),
                 pick_value($signed(limit_plan[REG_VEL_LO]), $signed(limit_plan[REG_VEL_HI])),
                 pick_value(0, limit_plan[REG_KP_HI][30:0]),
                 pick_value(0, limit_plan[REG_KD_HI][30:0]),
                 pick_value($signed(limit_plan[REG_TRQ_LO]), $signed(limit_plan[REG_TRQ_HI])),
                 {$urandom, $urandom});
  endtask

  task automatic send_random_feedback();
    logic [63:0] frame;
    case ($urandom_range(0, 9))
      0: frame = '0;
      1: frame = '1;
      default: frame = {$urandom, $urandom};
    endcase
    send_request(CMD_FEEDBACK, $urandom, $urandom, $urandom, $urandom, $urandom, frame);
  endtask

  initial begin : stimulus
    int pick;
    limit_plan = '{POS_LO_RST, POS_HI_RST, VEL_LO_RST, VEL_HI_RST,
                   TRQ_LO_RST, TRQ_HI_RST, {1'b0, KP_HI_RST}, {1'b0, KD_HI_RST}};
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: refused control, redundant exit, enter twice, limits, feedback extremes.
    send_request(CMD_CONTROL, 32'd100, 32'd100, 32'd100, 32'd100, 32'd100, '0);
    send_request(CMD_EXIT, '0, '0, '0, '0, '0, '1);
    send_request(CMD_ENTER, '1, '1, '1, '1, '1, '0);
    send_request(CMD_ENTER, '0, '0, '0, '0, '0, '0);
    send_request(CMD_CONTROL, POS_LO_RST, VEL_LO_RST, KP_LOW, KD_LOW, TRQ_LO_RST, '0);
    send_request(CMD_CONTROL, POS_HI_RST, VEL_HI_RST, {1'b0, KP_HI_RST}, {1'b0, KD_HI_RST},
                 TRQ_HI_RST, '1);
    send_request(CMD_CONTROL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, '0);
    send_request(CMD_CONTROL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, '1);
    send_request(CMD_CONTROL, '0, '0, '0, '0, '0, '0);
    send_request(CMD_CONTROL, 32'd1, -32'sd1, 32'd1, -32'sd1, 32'd1, '0);
    // feedback never touches the mode
    send_request(CMD_FEEDBACK, '0, '0, '0, '0, '0, 64'h0);
    send_request(CMD_FEEDBACK, '1, '1, '1, '1, '1, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(CMD_FEEDBACK, '0, '0, '0, '0, '0, 64'h5A80_0080_0800_7F80);
    send_request(CMD_CONTROL, 32'd5000, 32'd5000, 32'd5000, 32'd5000, 32'd5000, '0);
    send_request(CMD_EXIT, '0, '0, '0, '0, '0, '0);
    send_request(CMD_FEEDBACK, '0, '0, '0, '0, '0, 64'h0123_4567_89AB_CDEF);
    send_request(CMD_CONTROL, '0, '0, '0, '0, '0, '0);

    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: ;  // reset limits
        1: limit_plan = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1};
        // empty and inverted limits, gain limits masked to zero and to full scale
        2: limit_plan = '{32'd5, 32'd5, 32'd100, -32'sd100, -32'sd1, 32'd0,
                          32'h8000_0000, 32'hFFFF_FFFF};
        default: begin
          for (int i = 0; i < 6; i += 2) begin
            limit_plan[i]     = ($urandom_range(0, 3) == 0) ? $urandom
                                : 32'($signed($urandom_range(0, 2000000)) - 2000000);
            limit_plan[i + 1] = ($urandom_range(0, 3) == 0) ? $urandom
                                : limit_plan[i] + $urandom_range(1, 3000000);
          end
          limit_plan[REG_KP_HI] = $urandom;
          limit_plan[REG_KD_HI] = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 5000);
        end
      endcase
      if (phase > 0) apply_limits();
      if (phase == 3) hold_request = 1'b1;
      fast_phase = (phase == 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (!sent_mode && pick < 75) begin
          send_request(CMD_ENTER, $urandom, $urandom, $urandom, $urandom, $urandom,
                       {$urandom, $urandom});
        end else if (pick < 72) begin
          send_random_control();
        end else if (pick < 86) begin
          send_random_feedback();
        end else if (pick < 93) begin
          send_request(CMD_ENTER, $urandom, $urandom, $urandom, $urandom, $urandom,
                       {$urandom, $urandom});
        end else begin
          send_request(CMD_EXIT, $urandom, $urandom, $urandom, $urandom, $urandom,
                       {$urandom, $urandom});
        end
      end
    end
    fast_phase = 1'b0;

    // Drain: wait for every result, then let the block settle.
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (120) @(posedge clk);

    $display("covered %0d requests and %0d results over %0d limit settings", requests,
             results, settings);
    $display("included refused controls, redundant mode changes, empty and inverted limits");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
sv/svcfc_pkg.sv
sv/svcfc_controller.sv
sv/svcfc_datapath.sv
sv/servo_command_frame_codec_unit.sv
tb/sv/svcfc_frame_checker.sv
tb/sv/tb_servo_command_frame_codec_unit.sv
